### hdl/pget_pkg.sv
// Package of the presence-gated elapsed timer: field widths, event codes,
// BCD digit limits and the seven-segment font. No dependencies.
`default_nettype none

package pget_pkg;

  localparam int EchoW           = 16;
  localparam int EchoFields      = 5;
  localparam int SamplesPerRound = 5;
  localparam int SamplesUsed     = (SamplesPerRound > EchoFields) ? EchoFields
                                                                  : SamplesPerRound;
  localparam int NumDigits       = 6;
  localparam int SegW            = 8;
  localparam int TotalW          = 24;
  localparam int EventW          = 2;

  localparam logic [EchoW-1:0]  ThresholdReset = 16'd1740;
  localparam logic [TotalW-1:0] TotalMax       = {TotalW{1'b1}};

  typedef enum logic [EventW-1:0] {
    EvNone   = 2'd0,
    EvArrive = 2'd1,
    EvLeave  = 2'd2
  } event_e;

  typedef logic [3:0] bcd_t;

  // Highest value of each digit before it wraps to zero; digit 0 is seconds units.
  localparam bcd_t DigitLast [NumDigits] = '{4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd9};

  function automatic logic [SegW-1:0] seg_font(input bcd_t digit);
    logic [SegW-1:0] pattern;
    case (digit)
      4'd0: pattern = 8'h3F;
      4'd1: pattern = 8'h06;
      4'd2: pattern = 8'h5B;
      4'd3: pattern = 8'h4F;
      4'd4: pattern = 8'h66;
      4'd5: pattern = 8'h6D;
      4'd6: pattern = 8'h7D;
      4'd7: pattern = 8'h07;
      4'd8: pattern = 8'h7F;
      4'd9: pattern = 8'h67;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

### hdl/pget_if.sv
// Valid/ready channel interfaces of the presence-gated elapsed timer: one for
// the echo round items and one for the result items. No dependencies.
`default_nettype none

interface pget_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] echo_a;
  logic [15:0] echo_b;
  logic [15:0] echo_c;
  logic [15:0] echo_d;
  logic [15:0] echo_e;

  modport source (output valid, echo_a, echo_b, echo_c, echo_d, echo_e, input ready);
  modport sink   (input valid, echo_a, echo_b, echo_c, echo_d, echo_e, output ready);
endinterface

interface pget_out_if;
  logic        valid;
  logic        ready;
  logic        seated;
  logic [1:0]  change_event;
  logic [47:0] segment_word;
  logic [23:0] study_seconds;

  modport source (output valid, seated, change_event, segment_word, study_seconds,
                  input ready);
  modport sink   (input valid, seated, change_event, segment_word, study_seconds,
                  output ready);
endinterface

`default_nettype wire

### hdl/presence_gated_elapsed_timer.sv
// Top level of the presence-gated elapsed timer.
// Depends on pget_pkg, the channel interfaces in pget_if and pget_bcd_clock.
//
// Each item is one round of echo widths. A width below the threshold marks
// the seat as taken, and every width above it marks it as free; a width equal
// to the threshold does neither. While seated, each round shows the current
// HH:MM:SS digits as seven-segment patterns and then advances the clock by one
// second and the saturating seconds total. The block takes one item per cycle
// while the result channel is not stalled; each item passes through the input
// register and then the result register, and a stalled result holds both stages.
`default_nettype none

module presence_gated_elapsed_timer import pget_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [EchoW-1:0] cfg_wdata_i,
  pget_in_if.sink               in_ch,
  pget_out_if.source            out_ch
);

  logic [EchoW-1:0] threshold_q;
  logic             s1_valid_q;
  logic [EchoW-1:0] echo_q [EchoFields];
  logic             seated_q, seated_d;
  logic [TotalW-1:0] total_q, total_d;
  logic             advance;
  logic             tick;

  logic              out_valid_q;
  logic              out_seated_q;
  event_e            out_event_q, event_d;
  logic [NumDigits*SegW-1:0] out_word_q, word_d;
  logic [TotalW-1:0] out_total_q;

  logic [SamplesUsed-1:0] near, not_far;
  logic                   any_near, all_far;
  bcd_t [NumDigits-1:0]   digits;

  assign advance     = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      echo_q[0] <= in_ch.echo_a;
      echo_q[1] <= in_ch.echo_b;
      echo_q[2] <= in_ch.echo_c;
      echo_q[3] <= in_ch.echo_d;
      echo_q[4] <= in_ch.echo_e;
    end
  end

  for (genvar i = 0; i < SamplesUsed; i++) begin : g_cmp
    assign near[i]    = echo_q[i] <  threshold_q;
    assign not_far[i] = echo_q[i] <= threshold_q;
  end

  assign any_near = |near;
  assign all_far  = ~|not_far;

  always_comb begin
    seated_d = seated_q;
    event_d  = EvNone;
    if (!seated_q) begin
      if (any_near) begin
        seated_d = 1'b1;
        event_d  = EvArrive;
      end
    end else if (all_far) begin
      seated_d = 1'b0;
      event_d  = EvLeave;
    end
  end

  assign tick = advance && s1_valid_q && seated_d;

  always_comb begin
    word_d = '0;
    if (seated_d) begin
      for (int k = 0; k < NumDigits; k++) begin
        word_d[k*SegW +: SegW] = seg_font(digits[k]);
      end
    end
  end

  assign total_d = (tick && total_q != TotalMax) ? total_q + 1'b1 : total_q;

  pget_bcd_clock u_clock (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .digits_o (digits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seated_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        seated_q <= seated_d;
        total_q  <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_seated_q <= seated_d;
      out_event_q  <= event_d;
      out_word_q   <= word_d;
      out_total_q  <= total_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.seated        = out_seated_q;
  assign out_ch.change_event  = out_event_q;
  assign out_ch.segment_word  = out_word_q;
  assign out_ch.study_seconds = out_total_q;

`ifndef NO_ASSERTIONS
  a_arrive_seated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_event_q == EvArrive |-> out_seated_q)
    else $error("arrival item reports a free seat");

  a_leave_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_event_q == EvLeave |-> !out_seated_q)
    else $error("departure item reports a taken seat");

  a_blank_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_seated_q |-> out_word_q == '0)
    else $error("segments lit while the seat is free");

  a_total_follows_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick |=> $stable(total_q))
    else $error("seconds total moved without a tick");
`endif

endmodule

`default_nettype wire

### hdl/pget_bcd_clock.sv
// HH:MM:SS BCD time counter that advances one second per tick.
// Depends on pget_pkg for the digit type and the digit limits.
`default_nettype none

module pget_bcd_clock import pget_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 tick_i,
  output bcd_t [NumDigits-1:0]      digits_o
);

  bcd_t [NumDigits-1:0] digits_q, digits_d;

  always_comb begin
    logic carry;
    carry    = tick_i;
    digits_d = digits_q;
    for (int k = 0; k < NumDigits; k++) begin
      if (carry) begin
        if (digits_q[k] >= DigitLast[k]) begin
          digits_d[k] = 4'd0;
        end else begin
          digits_d[k] = digits_q[k] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
    end else begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

`default_nettype wire
